// ===== design/mlft_pkg.sv =====
// Shared types, constants and helpers for the MAC learning table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mlft_pkg;

  // Default geometry of the table
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_PORT_COUNT  = 4;

  // Entries held by one cell of the chain, and its offset width
  localparam int unsigned SLICE_DEPTH = 64;
  localparam int unsigned SLICE_W     = $clog2(SLICE_DEPTH);

  // Field widths of the frame header and the result
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned PORT_W = 2;
  localparam int unsigned MASK_W = 4;

  localparam logic [MAC_W-1:0] ALL_ONES_MAC = {MAC_W{1'b1}};

  // Learning outcome codes
  typedef enum logic [1:0] {
    LEARN_UPDATED = 2'd0,
    LEARN_ADDED   = 2'd1,
    LEARN_FULL    = 2'd2
  } learn_status_e;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;      // start of a new header: drop old hits
    logic rd_en;      // sweep read of the slice memories
    logic wr_update;  // rewrite the port of the matched source entry
    logic wr_append;  // append the source at the fill position
  } ctrl_t;

  // Lookup summary handed from cell to cell
  typedef struct packed {
    logic              src_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } tok_t;

  // Mask of the ports that exist within the egress field
  function automatic logic [MASK_W-1:0] port_mask(int unsigned port_count);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int unsigned p = 0; p < MASK_W; p++) begin
      if (p < port_count) m[p] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== design/mlft_cell.sv =====
// One cell of the lookup chain: a 64-entry slice of the table, its sweep
// compare and its stage of the summary chain. Depends on mlft_pkg.
`timescale 1ns / 1ps

module mlft_cell import mlft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned CELL_ID     = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctrl_t                               ctrl_i,
  input  logic [SLICE_W-1:0]                  rd_addr_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]    used_count_i,
  input  logic [MAC_W-1:0]                    src_mac_i,
  input  logic [MAC_W-1:0]                    dst_mac_i,
  input  logic [PORT_W-1:0]                   in_port_i,
  input  tok_t                                tok_i,
  output tok_t                                tok_o
);

  localparam int unsigned CELL_COUNT = (TABLE_DEPTH + SLICE_DEPTH - 1) / SLICE_DEPTH;
  localparam int unsigned GI_W       = $clog2(CELL_COUNT) + SLICE_W;

  // Slice storage
  logic [MAC_W-1:0]  addr_mem [SLICE_DEPTH];
  logic [PORT_W-1:0] port_mem [SLICE_DEPTH];

  logic [MAC_W-1:0]   rd_mac_q;
  logic [PORT_W-1:0]  rd_port_q;
  logic [SLICE_W-1:0] rd_off_q;
  logic               rd_vld_q;

  logic               src_hit_q;
  logic               dst_hit_q;
  logic [SLICE_W-1:0] src_off_q;
  logic [PORT_W-1:0]  dst_port_q;
  tok_t               tok_q;
  tok_t               tok_d;

  logic [GI_W:0]      gidx;
  logic [GI_W:0]      cnt_x;
  logic               entry_live;
  logic               app_here;
  logic               src_eq;
  logic               dst_eq;

  // Position of the entry under compare and of the fill point
  assign gidx       = (GI_W+1)'(CELL_ID * SLICE_DEPTH) + (GI_W+1)'(rd_off_q);
  assign cnt_x      = (GI_W+1)'(used_count_i);
  assign entry_live = rd_vld_q && (gidx < cnt_x);
  assign app_here   = (cnt_x[GI_W:SLICE_W] == (GI_W+1-SLICE_W)'(CELL_ID));
  assign src_eq     = (rd_mac_q == src_mac_i);
  assign dst_eq     = (rd_mac_q == dst_mac_i);

  // Write the slice: port rewrite on a source hit, full entry on append
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_update && src_hit_q) begin
      port_mem[src_off_q] <= in_port_i;
    end else if (ctrl_i.wr_append && app_here) begin
      addr_mem[cnt_x[SLICE_W-1:0]] <= src_mac_i;
      port_mem[cnt_x[SLICE_W-1:0]] <= in_port_i;
    end
  end

  // Read the slice during the sweep
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_mac_q  <= addr_mem[rd_addr_i];
      rd_port_q <= port_mem[rd_addr_i];
      rd_off_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
    end
  end

  // Collect hits of this slice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_hit_q <= 1'b0;
      dst_hit_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      src_hit_q <= 1'b0;
      dst_hit_q <= 1'b0;
    end else if (entry_live) begin
      if (src_eq) src_hit_q <= 1'b1;
      if (dst_eq) dst_hit_q <= 1'b1;
    end
  end

  // Hold the slot of the source hit and the port of the destination hit
  always_ff @(posedge clk_i) begin
    if (entry_live && src_eq) src_off_q  <= rd_off_q;
    if (entry_live && dst_eq) dst_port_q <= rd_port_q;
  end

  // Merge this slice into the summary and hand it on
  always_comb begin
    tok_d.src_hit  = tok_i.src_hit | src_hit_q;
    tok_d.dst_hit  = tok_i.dst_hit | dst_hit_q;
    tok_d.dst_port = dst_hit_q ? dst_port_q : tok_i.dst_port;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== design/mlft_ctrl.sv =====
// Sequencer of the MAC learning table: sweep, chain drain and write-back,
// plus the fill count of the table. Depends on mlft_pkg.
`timescale 1ns / 1ps

module mlft_ctrl import mlft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic                             src_hit_i,
  output logic                             busy,
  output ctrl_t                            ctrl_o,
  output logic [SLICE_W-1:0]               rd_addr_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] used_count_o,
  output logic                             report_o
);

  localparam int unsigned CELL_COUNT = (TABLE_DEPTH + SLICE_DEPTH - 1) / SLICE_DEPTH;
  localparam int unsigned GI_W       = $clog2(CELL_COUNT) + SLICE_W;
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_CHAIN = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [GI_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              room;

  assign room = (used_q < CNT_W'(TABLE_DEPTH));

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (cnt_q == GI_W'(SLICE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + GI_W'(1);
        end
      end
      ST_DRAIN: begin
        cnt_d   = '0;
        state_d = ST_CHAIN;
      end
      ST_CHAIN: begin
        if (cnt_q == GI_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + GI_W'(1);
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        cnt_d   = '0;
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive the cells
  always_comb begin
    ctrl_o.clear     = (state_q == ST_IDLE) && start;
    ctrl_o.rd_en     = (state_q == ST_SWEEP);
    ctrl_o.wr_update = (state_q == ST_WRITE) && src_hit_i;
    ctrl_o.wr_append = (state_q == ST_WRITE) && !src_hit_i && room;
  end

  assign used_d = ctrl_o.wr_append ? used_q + CNT_W'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign rd_addr_o    = cnt_q[SLICE_W-1:0];
  assign used_count_o = used_q;
  assign report_o     = (state_q == ST_WRITE);

endmodule

// ===== design/mac_learning_forwarding_table_top.sv =====
// Top level of the MAC learning table: header capture, cell chain,
// sequencer and result register. Depends on mlft_pkg, mlft_cell, mlft_ctrl.
`timescale 1ns / 1ps

// Learning bridge table. A header (source MAC, destination MAC, ingress
// port) transfers on a rising edge with start high and busy low. The source
// is learned (port rewritten, or appended while the table has room), then
// the egress ports are chosen; entries never age out. The table is split
// into cells of 64 entries, each with its own single-port slice memory.
// All cells sweep their slices in parallel, one entry a cycle, and then a
// lookup summary walks down the chain of C = ceil(TABLE_DEPTH / 64) cells
// one cell a cycle. The sequencer steps through sweep, drain, chain and
// write states; result_valid_o is registered from the write state and
// pulses for one cycle, and busy drops in that same cycle, so the next
// header can transfer while the result is shown. The result cannot be held
// off: it must be taken in the cycle it is strobed. No clearing pass is
// needed after reset; only entries below the fill count are ever compared.
module mac_learning_forwarding_table_top import mlft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned PORT_COUNT  = DEF_PORT_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [MAC_W-1:0]  src_mac_i,
  input  logic [MAC_W-1:0]  dst_mac_i,
  input  logic [PORT_W-1:0] in_port_i,
  output logic              result_valid_o,
  output logic [MASK_W-1:0] egress_mask_o,
  output logic              flooded_o,
  output logic [1:0]        learn_status_o
);

  localparam int unsigned CELL_COUNT = (TABLE_DEPTH + SLICE_DEPTH - 1) / SLICE_DEPTH;
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LATENCY    = SLICE_DEPTH + CELL_COUNT + 3;
  localparam logic [MASK_W-1:0] PMASK = port_mask(PORT_COUNT);

  logic [MAC_W-1:0]   src_q;
  logic [MAC_W-1:0]   dst_q;
  logic [PORT_W-1:0]  port_q;

  ctrl_t              ctrl;
  logic [SLICE_W-1:0] rd_addr;
  logic [CNT_W-1:0]   used_count;
  logic               report;
  tok_t               tok [CELL_COUNT+1];

  logic               dst_self;
  logic               learned;
  logic               known;
  logic [PORT_W-1:0]  lp;
  learn_status_e      status;

  logic               valid_q;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic               flood_q, flood_d;
  learn_status_e      status_q;

  // Capture the header on transfer
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      src_q  <= src_mac_i;
      dst_q  <= dst_mac_i;
      port_q <= in_port_i;
    end
  end

  mlft_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .src_hit_i    (tok[CELL_COUNT].src_hit),
    .busy         (busy),
    .ctrl_o       (ctrl),
    .rd_addr_o    (rd_addr),
    .used_count_o (used_count),
    .report_o     (report)
  );

  // Chain of table cells
  assign tok[0] = '0;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    mlft_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_ID     (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .rd_addr_i    (rd_addr),
      .used_count_i (used_count),
      .src_mac_i    (src_q),
      .dst_mac_i    (dst_q),
      .in_port_i    (port_q),
      .tok_i        (tok[k]),
      .tok_o        (tok[k+1])
    );
  end

  // Pick egress ports; a destination equal to the source sees the new learn
  always_comb begin
    dst_self = (dst_q == src_q);
    learned  = ctrl.wr_update | ctrl.wr_append;
    known    = (dst_q != ALL_ONES_MAC) && (dst_self ? learned : tok[CELL_COUNT].dst_hit);
    lp       = dst_self ? port_q : tok[CELL_COUNT].dst_port;
    if (known) begin
      mask_d  = (MASK_W'(1) << lp) & PMASK;
      flood_d = 1'b0;
    end else begin
      mask_d  = PMASK & ~(MASK_W'(1) << port_q);
      flood_d = 1'b1;
    end
    priority if (ctrl.wr_update) begin
      status = LEARN_UPDATED;
    end else if (ctrl.wr_append) begin
      status = LEARN_ADDED;
    end else begin
      status = LEARN_FULL;
    end
  end

  // Register the result for its one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      mask_q   <= mask_d;
      flood_q  <= flood_d;
      status_q <= status;
    end
  end

  assign result_valid_o = valid_q;
  assign egress_mask_o  = mask_q;
  assign flooded_o      = flood_q;
  assign learn_status_o = status_q;

  // Every transferred header yields its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(LATENCY) result_valid_o)
    else $error("result strobe missing after header transfer");

  // The result strobe falls in an idle cycle, ready for the next header
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while busy");

  // The fill count grows by one at most and never passes the depth
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_count != $past(used_count)) |-> (used_count == $past(used_count) + CNT_W'(1)))
    else $error("fill count jumped");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for the MAC learning forwarding table: table-driven
// directed headers, then randomized traffic checked against a local predictor.
// Depends on mlft_pkg and mac_learning_forwarding_table_top.
`timescale 1ns / 1ps

module tb;
  import mlft_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int unsigned PORT_COUNT  = DEF_PORT_COUNT;
  localparam int unsigned CELLS       = (TABLE_DEPTH + SLICE_DEPTH - 1) / SLICE_DEPTH;
  localparam int unsigned TAIL_CYCLES = 2 * (SLICE_DEPTH + CELLS + 3);
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_SHOWN   = 10;

  localparam logic [MASK_W-1:0] ALL_PORTS =
    (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << PORT_COUNT) - 1);

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_A    = 48'h0200_0000_000a;
  localparam logic [MAC_W-1:0] MAC_B    = 48'h0200_0000_000b;
  localparam logic [MAC_W-1:0] MAC_C    = 48'h0200_0000_000c;
  localparam logic [MAC_W-1:0] MAC_D    = 48'h0a0b_0c0d_0e0f;
  localparam logic [MAC_W-1:0] MAC_E    = 48'h5555_aaaa_5555;
  localparam logic [MAC_W-1:0] MAC_LOHI = 48'h7fff_ffff_ffff;
  localparam logic [MAC_W-1:0] MAC_HILO = 48'h8000_0000_0000;
  localparam logic [MAC_W-1:0] MAC_NEAR = 48'hffff_ffff_fffe;

  typedef struct packed {
    logic [MASK_W-1:0] egress;
    logic              flooded;
    learn_status_e     status;
  } fwd_result_t;

  typedef struct packed {
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              literal;
    fwd_result_t       res;
  } header_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MAC_W-1:0]  src_mac_i = '0;
  logic [MAC_W-1:0]  dst_mac_i = '0;
  logic [PORT_W-1:0] in_port_i = '0;
  logic              result_valid_o;
  logic [MASK_W-1:0] egress_mask_o;
  logic              flooded_o;
  logic [1:0]        learn_status_o;

  // Predictor state: learned addresses and ports, and the fill count
  logic [MAC_W-1:0]  learned_mac [TABLE_DEPTH];
  logic [PORT_W-1:0] learned_port [TABLE_DEPTH];
  int unsigned       fill_cnt = 0;

  fwd_result_t pending_fwd_q [$];
  header_row_t directed_rows [$];
  logic [MAC_W-1:0] pool_mac [64];
  int unsigned idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  mac_learning_forwarding_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .src_mac_i     (src_mac_i),
    .dst_mac_i     (dst_mac_i),
    .in_port_i     (in_port_i),
    .result_valid_o(result_valid_o),
    .egress_mask_o (egress_mask_o),
    .flooded_o     (flooded_o),
    .learn_status_o(learn_status_o)
  );

  always #1 clk_i = ~clk_i;

  // Return the slot holding an address among the valid entries, or -1
  function automatic int find_slot(input logic [MAC_W-1:0] addr);
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (learned_mac[i] == addr) return int'(i);
    end
    return -1;
  endfunction

  // Learn the source, then choose the egress ports for the destination
  function automatic fwd_result_t learn_and_forward(input logic [MAC_W-1:0] src,
                                                    input logic [MAC_W-1:0] dst,
                                                    input logic [PORT_W-1:0] port);
    fwd_result_t r;
    int slot;
    slot = find_slot(src);
    if (slot >= 0) begin
      learned_port[slot] = port;
      r.status = LEARN_UPDATED;
    end else if (fill_cnt < TABLE_DEPTH) begin
      learned_mac[fill_cnt]  = src;
      learned_port[fill_cnt] = port;
      fill_cnt++;
      r.status = LEARN_ADDED;
    end else begin
      r.status = LEARN_FULL;
    end
    slot = (dst == ALL_ONES_MAC) ? -1 : find_slot(dst);
    if (slot >= 0) begin
      r.egress  = (MASK_W'(1) << learned_port[slot]) & ALL_PORTS;
      r.flooded = 1'b0;
    end else begin
      r.egress  = ALL_PORTS & ~(MASK_W'(1) << port);
      r.flooded = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  // Draw an address: broadcast, fresh, or from the pool (0 = learned table)
  function automatic logic [MAC_W-1:0] pick_addr(input int unsigned bcast_pct,
                                                 input int unsigned fresh_pct,
                                                 input int unsigned pool_n);
    int unsigned r;
    r = $urandom_range(99);
    if (r < bcast_pct) return ALL_ONES_MAC;
    if (r < bcast_pct + fresh_pct) return rand_mac();
    if (pool_n == 0) return learned_mac[$urandom_range(fill_cnt - 1)];
    return pool_mac[$urandom_range(pool_n - 1)];
  endfunction

  task automatic add_row(input logic [MAC_W-1:0] s, input logic [MAC_W-1:0] d,
                         input logic [PORT_W-1:0] p, input logic lit,
                         input logic [MASK_W-1:0] eg, input logic fl,
                         input learn_status_e st);
    header_row_t row;
    row.src = s;
    row.dst = d;
    row.port = p;
    row.literal = lit;
    row.res.egress = eg;
    row.res.flooded = fl;
    row.res.status = st;
    directed_rows.push_back(row);
  endtask

  // Present one header, hold it until the transfer, then record the expectation
  task automatic send_header(input logic [MAC_W-1:0] s, input logic [MAC_W-1:0] d,
                             input logic [PORT_W-1:0] p, input logic lit,
                             input fwd_result_t lit_res);
    fwd_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    src_mac_i <= s;
    dst_mac_i <= d;
    in_port_i <= p;
    do @(posedge clk_i); while (busy);
    pred = learn_and_forward(s, d, p);
    pending_fwd_q.push_back(lit ? lit_res : pred);
  endtask

  task automatic send_random(input int unsigned n_items, input int unsigned pool_n,
                             input int unsigned src_fresh, input int unsigned dst_bcast,
                             input int unsigned dst_fresh, input logic stop_at_full);
    logic [MAC_W-1:0] s;
    logic [MAC_W-1:0] d;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (stop_at_full && fill_cnt >= TABLE_DEPTH) break;
      s = pick_addr(2, src_fresh, pool_n);
      d = ($urandom_range(19) == 0) ? s : pick_addr(dst_bcast, dst_fresh, pool_n);
      send_header(s, d, PORT_W'($urandom_range(3)), 1'b0, '0);
    end
  endtask

  // Check each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    fwd_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (pending_fwd_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("unexpected result: mask=%h flood=%0d status=%0d",
                   egress_mask_o, flooded_o, learn_status_o);
      end else begin
        exp_res = pending_fwd_q.pop_front();
        if (egress_mask_o !== exp_res.egress || flooded_o !== exp_res.flooded ||
            learn_status_o !== 2'(exp_res.status)) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch: exp mask=%h flood=%0d status=%0d, got mask=%h flood=%0d status=%0d",
                     exp_res.egress, exp_res.flooded, exp_res.status,
                     egress_mask_o, flooded_o, learn_status_o);
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // Directed headers; literal rows hold values readable at a glance
    add_row(MAC_A,    ALL_ONES_MAC,  2'd0, 1'b1, 4'b1110, 1'b1, LEARN_ADDED);
    add_row(MAC_ZERO, ALL_ONES_MAC,  2'd3, 1'b1, 4'b0111, 1'b1, LEARN_ADDED);
    // broadcast source is learned like any address
    add_row(ALL_ONES_MAC, MAC_ZERO,  2'd1, 1'b1, 4'b1000, 1'b0, LEARN_ADDED);
    // learned all-ones destination still floods
    add_row(MAC_B,    ALL_ONES_MAC,  2'd2, 1'b1, 4'b1011, 1'b1, LEARN_ADDED);
    // source equal to destination returns to ingress
    add_row(MAC_C,    MAC_C,         2'd2, 1'b1, 4'b0100, 1'b0, LEARN_ADDED);
    add_row(MAC_ZERO, MAC_A,         2'd1, 1'b1, 4'b0001, 1'b0, LEARN_UPDATED);
    add_row(MAC_A,    MAC_A,         2'd0, 1'b1, 4'b0001, 1'b0, LEARN_UPDATED);
    // unknown destination floods
    add_row(MAC_D,    MAC_E,         2'd3, 1'b1, 4'b0111, 1'b1, LEARN_ADDED);
    add_row(MAC_E,    MAC_D,         2'd0, 1'b1, 4'b1000, 1'b0, LEARN_ADDED);
    add_row(ALL_ONES_MAC, ALL_ONES_MAC, 2'd3, 1'b1, 4'b0111, 1'b1, LEARN_UPDATED);
    add_row(MAC_B,    MAC_ZERO,      2'd3, 1'b1, 4'b0010, 1'b0, LEARN_UPDATED);
    add_row(MAC_LOHI, MAC_HILO,      2'd1, 1'b1, 4'b1101, 1'b1, LEARN_ADDED);
    add_row(MAC_HILO, MAC_LOHI,      2'd2, 1'b1, 4'b0010, 1'b0, LEARN_ADDED);
    add_row(MAC_NEAR, MAC_NEAR,      2'd3, 1'b1, 4'b1000, 1'b0, LEARN_ADDED);
    add_row(MAC_A,    MAC_E,         2'd2, 1'b0, '0, 1'b0, LEARN_UPDATED);
    add_row(MAC_C,    MAC_B,         2'd1, 1'b0, '0, 1'b0, LEARN_UPDATED);
    add_row(MAC_E,    MAC_C,         2'd3, 1'b0, '0, 1'b0, LEARN_UPDATED);
    add_row(MAC_HILO, MAC_NEAR,      2'd0, 1'b0, '0, 1'b0, LEARN_UPDATED);

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_header(directed_rows[i].src, directed_rows[i].dst, directed_rows[i].port,
                  directed_rows[i].literal, directed_rows[i].res);

    // Small pool, back-to-back: heavy reuse of learned entries
    foreach (pool_mac[i]) pool_mac[i] = rand_mac();
    idle_pct = 0;
    send_random(300, 16, 10, 10, 20, 1'b0);

    // Wider pool with a sender that often idles before a header
    foreach (pool_mac[i]) pool_mac[i] = rand_mac();
    idle_pct = 64;
    send_random(300, 64, 10, 10, 20, 1'b0);

    // Fill the table with fresh sources
    idle_pct = 0;
    send_random(1500, 0, 85, 10, 30, 1'b1);

    // Full table: fresh sources are refused, known ones still update
    idle_pct = 25;
    send_random(400, 0, 50, 15, 35, 1'b0);

    // Drop start, drain the expectations, then let the pipeline settle
    start <= 1'b0;
    while (pending_fwd_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_fwd_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
